// ===== hw/rtl/ik_pkg.sv =====
`default_nettype none

package ik_pkg;

    // Keying phases, in the encoding seen on the phase output
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_START  = 3'd1,
        PH_DIT    = 3'd2,
        PH_DITGAP = 3'd3,
        PH_DAH    = 3'd4,
        PH_DAHGAP = 3'd5,
        PH_END    = 3'd6
    } ik_phase_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_WPM         = 2'd0,
        REG_START_DELAY = 2'd1,
        REG_END_DELAY   = 2'd2,
        REG_NONE        = 2'd3
    } ik_reg_t;

    localparam int CFG_DATA_W = 8;
    localparam int TICKS_W    = 10;
    localparam int DIT_W      = 8;

    localparam logic [5:0]       WPM_RESET         = 6'd20;
    localparam logic [DIT_W-1:0] DIT_TICKS_RESET   = 8'd60;
    localparam logic [7:0]       START_DELAY_RESET = 8'd10;
    localparam logic [7:0]       END_DELAY_RESET   = 8'd50;

    // 1200 / wpm with wpm clamped to 5..60
    localparam logic [DIT_W-1:0] DIT_TICKS_LUT [64] = '{
        8'd240, 8'd240, 8'd240, 8'd240, 8'd240, 8'd240, 8'd200, 8'd171,
        8'd150, 8'd133, 8'd120, 8'd109, 8'd100, 8'd92,  8'd85,  8'd80,
        8'd75,  8'd70,  8'd66,  8'd63,  8'd60,  8'd57,  8'd54,  8'd52,
        8'd50,  8'd48,  8'd46,  8'd44,  8'd42,  8'd41,  8'd40,  8'd38,
        8'd37,  8'd36,  8'd35,  8'd34,  8'd33,  8'd32,  8'd31,  8'd30,
        8'd30,  8'd29,  8'd28,  8'd27,  8'd27,  8'd26,  8'd26,  8'd25,
        8'd25,  8'd24,  8'd24,  8'd23,  8'd23,  8'd22,  8'd22,  8'd21,
        8'd21,  8'd21,  8'd20,  8'd20,  8'd20,  8'd20,  8'd20,  8'd20
    };

    typedef struct packed {
        logic dit_pressed;
        logic dah_pressed;
    } ik_in_t;

    typedef struct packed {
        logic       key_down;
        logic       tx_enable;
        logic [2:0] phase;
    } ik_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/iambic_keyer.sv =====
`default_nettype none

// Iambic Morse keyer. Each input transfer is one millisecond tick carrying the
// dit and dah paddle levels; each tick produces exactly one output transfer with
// key_down, tx_enable and the keying phase reached after that tick. The keyer
// runs start delay -> dit (one dit time) or dah (three dit times) -> gap of one
// dit time -> next element or end delay -> idle, alternating elements while
// both paddles are held; a dit pressed during a dah gap is remembered and sent
// next. Throughput is one tick per clock while in_stall is low: the phase/timer
// update is a single combinational step from the state registers into the
// output register. A one-entry skid register behind the output register lets
// a tick be taken while a result is still waiting, so in_stall rises only once
// both the output register and the skid entry hold a result. out_valid is
// registered. Writing words_per_minute looks the dit time
// (1200/wpm ms, wpm clamped to 5..60) up in a table; write registers only while
// no transfer is in flight. A running countdown is left alone, new values apply
// at the next timer load. Reset: 20 wpm (60 ms dit), start delay 10 ticks, end
// delay 50 ticks.
module iambic_keyer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [ik_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                          in_valid,
    output      logic                          in_stall,
    input  wire ik_pkg::ik_in_t                in_data,
    output      logic                          out_valid,
    input  wire logic                          out_stall,
    output      ik_pkg::ik_out_t               out_data
);
    import ik_pkg::*;

    // Configuration
    logic [DIT_W-1:0]   dit_ticks_reg;
    logic [7:0]         start_delay_reg;
    logic [7:0]         end_delay_reg;

    // Keying state
    ik_phase_t          phase_reg, phase_next;
    logic [TICKS_W-1:0] ticks_reg, ticks_next;
    logic               dit_mem_reg, dit_mem_next;

    // Output register plus skid entry
    ik_out_t            out_reg, skid_reg, result;
    logic               out_valid_reg, skid_valid_reg;

    logic               in_take, out_take, expired, dit, dah;
    logic [TICKS_W-1:0] ticks_dec, dit_time, dah_time;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dit_ticks_reg   <= DIT_TICKS_RESET;
            start_delay_reg <= START_DELAY_RESET;
            end_delay_reg   <= END_DELAY_RESET;
        end
        else if (cfg_write)
        begin
            case (ik_reg_t'(cfg_index))
                REG_WPM:         dit_ticks_reg   <= DIT_TICKS_LUT[cfg_data[5:0]];
                REG_START_DELAY: start_delay_reg <= cfg_data;
                REG_END_DELAY:   end_delay_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign dit       = in_data.dit_pressed;
    assign dah       = in_data.dah_pressed;
    assign expired   = (ticks_reg <= TICKS_W'(1));
    assign ticks_dec = expired ? '0 : ticks_reg - TICKS_W'(1);
    assign dit_time  = TICKS_W'(dit_ticks_reg);
    // 3 * dit = dit + 2 * dit, at most 720
    assign dah_time  = TICKS_W'(dit_ticks_reg) + {1'b0, dit_ticks_reg, 1'b0};

    // Next phase, timer and dit memory for one tick
    always_comb
    begin
        phase_next   = phase_reg;
        ticks_next   = ticks_reg;
        dit_mem_next = dit_mem_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (dit || dah)
                begin
                    phase_next = PH_START;
                    ticks_next = TICKS_W'(start_delay_reg);
                end
            end
            PH_START:
            begin
                ticks_next = ticks_dec;
                if (expired)
                begin
                    if (dit)
                    begin
                        phase_next = PH_DIT;
                        ticks_next = dit_time;
                    end
                    else if (dah)
                    begin
                        phase_next = PH_DAH;
                        ticks_next = dah_time;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        ticks_next = '0;
                    end
                end
            end
            PH_DIT:
            begin
                ticks_next = ticks_dec;
                if (expired)
                begin
                    phase_next = PH_DITGAP;
                    ticks_next = dit_time;
                end
            end
            PH_DITGAP:
            begin
                ticks_next = ticks_dec;
                if (expired)
                begin
                    if (dah)
                    begin
                        phase_next = PH_DAH;
                        ticks_next = dah_time;
                    end
                    else if (dit)
                    begin
                        phase_next = PH_DIT;
                        ticks_next = dit_time;
                    end
                    else
                    begin
                        phase_next = PH_END;
                        ticks_next = TICKS_W'(end_delay_reg);
                    end
                end
            end
            PH_DAH:
            begin
                ticks_next = ticks_dec;
                if (expired)
                begin
                    phase_next = PH_DAHGAP;
                    ticks_next = dit_time;
                end
            end
            PH_DAHGAP:
            begin
                // dit presses accumulate over the whole gap
                dit_mem_next = dit_mem_reg | dit;
                ticks_next   = ticks_dec;
                if (expired)
                begin
                    if (dit_mem_reg || dit)
                    begin
                        dit_mem_next = 1'b0;
                        phase_next   = PH_DIT;
                        ticks_next   = dit_time;
                    end
                    else if (dah)
                    begin
                        phase_next = PH_DAH;
                        ticks_next = dah_time;
                    end
                    else
                    begin
                        phase_next = PH_END;
                        ticks_next = TICKS_W'(end_delay_reg);
                    end
                end
            end
            PH_END:
            begin
                ticks_next = ticks_dec;
                if (expired)
                begin
                    phase_next = PH_IDLE;
                    ticks_next = '0;
                end
                else if (dit || dah)
                begin
                    // re-press during end delay: short restart
                    phase_next = PH_START;
                    ticks_next = TICKS_W'(1);
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                ticks_next = '0;
            end
        endcase
    end

    // Result fields come from the phase after this tick
    always_comb
    begin
        result.phase     = phase_next;
        result.tx_enable = (phase_next != PH_IDLE);
        case (phase_next)
            PH_DIT, PH_DAH: result.key_down = 1'b1;
            default:        result.key_down = 1'b0;
        endcase
    end

    assign in_stall = skid_valid_reg;
    assign in_take  = in_valid && !skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            ticks_reg   <= '0;
            dit_mem_reg <= 1'b0;
        end
        else if (in_take)
        begin
            phase_reg   <= phase_next;
            ticks_reg   <= ticks_next;
            dit_mem_reg <= dit_mem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_take)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload: skid drains into the output register first
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_take)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_reg <= result;
            end
            else
            begin
                out_reg <= result;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ik_checker.sv =====
`default_nettype none

module ik_checker (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_stall,
    input  wire logic            out_valid,
    input  wire logic            out_stall,
    input  wire ik_pkg::ik_out_t out_data
);
    import ik_pkg::*;

    // Stalled output transfer holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    // Input is only stalled when a result is pending
    a_stall_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no pending result");

    a_tx_enable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.tx_enable == (out_data.phase != PH_IDLE)))
        else $error("tx_enable disagrees with phase");

    a_key_down: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.key_down ==
            ((out_data.phase == PH_DIT) || (out_data.phase == PH_DAH))))
        else $error("key_down disagrees with phase");

    // Keying always passes through the start delay out of idle
    a_idle_exit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_data.phase == PH_IDLE
        |=> !out_valid || out_data.phase == PH_IDLE || out_data.phase == PH_START)
        else $error("left idle without start delay");

endmodule

bind iambic_keyer ik_checker u_ik_checker (.*);

`default_nettype wire

// ===== tb/keyer_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels and the register port of the keyer, keeps its own copy
// of the keying machine, and compares every output transfer with the oldest
// predicted tick.
module keyer_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [1:0]                    cfg_index,
    input  logic [ik_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  ik_pkg::ik_in_t                in_data,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  ik_pkg::ik_out_t               out_data,
    output int                            mismatches,
    output int                            pending,
    output int                            checked
);
    import ik_pkg::*;

    ik_phase_t          kphase;
    logic [TICKS_W-1:0] ticks;
    logic               dit_mem;
    logic [DIT_W-1:0]   dit_len;
    logic [7:0]         start_len;
    logic [7:0]         end_len;

    ik_out_t            due_outputs[$];
    int                 miss_cnt;
    int                 seen_cnt;

    // dit length in ticks, speed clamped to 5..60 wpm
    function automatic logic [DIT_W-1:0] dit_time_for(logic [5:0] wpm);
        int w;
        w = wpm;
        if (w < 5)
            w = 5;
        if (w > 60)
            w = 60;
        return DIT_W'(1200 / w);
    endfunction

    function automatic void enter_phase(ik_phase_t ph, logic [TICKS_W-1:0] n);
        kphase = ph;
        ticks  = n;
    endfunction

    // count one tick of a timed phase; true once the load has run out
    function automatic logic timer_done();
        if (ticks <= TICKS_W'(1))
        begin
            ticks = '0;
            return 1'b1;
        end
        ticks = ticks - TICKS_W'(1);
        return 1'b0;
    endfunction

    task automatic step_keyer(input ik_in_t pad, output ik_out_t res);
        logic [TICKS_W-1:0] dah_len;
        logic               dit;
        logic               dah;
        dit     = pad.dit_pressed;
        dah     = pad.dah_pressed;
        dah_len = TICKS_W'(3 * dit_len);
        case (kphase)
            PH_IDLE:
            begin
                if (dit || dah)
                    enter_phase(PH_START, TICKS_W'(start_len));
            end
            PH_START:
            begin
                if (timer_done())
                begin
                    if (dit)
                        enter_phase(PH_DIT, TICKS_W'(dit_len));
                    else if (dah)
                        enter_phase(PH_DAH, dah_len);
                    else
                        enter_phase(PH_IDLE, '0);
                end
            end
            PH_DIT:
            begin
                if (timer_done())
                    enter_phase(PH_DITGAP, TICKS_W'(dit_len));
            end
            PH_DITGAP:
            begin
                if (timer_done())
                begin
                    if (dah)
                        enter_phase(PH_DAH, dah_len);
                    else if (dit)
                        enter_phase(PH_DIT, TICKS_W'(dit_len));
                    else
                        enter_phase(PH_END, TICKS_W'(end_len));
                end
            end
            PH_DAH:
            begin
                if (timer_done())
                    enter_phase(PH_DAHGAP, TICKS_W'(dit_len));
            end
            PH_DAHGAP:
            begin
                // dit memory accumulates over the whole gap
                if (dit)
                    dit_mem = 1'b1;
                if (timer_done())
                begin
                    if (dit_mem)
                    begin
                        dit_mem = 1'b0;
                        enter_phase(PH_DIT, TICKS_W'(dit_len));
                    end
                    else if (dah)
                        enter_phase(PH_DAH, dah_len);
                    else
                        enter_phase(PH_END, TICKS_W'(end_len));
                end
            end
            PH_END:
            begin
                if (timer_done())
                    enter_phase(PH_IDLE, '0);
                else if (dit || dah)
                    enter_phase(PH_START, TICKS_W'(1));
            end
            default:
                enter_phase(PH_IDLE, '0);
        endcase
        res.key_down  = (kphase == PH_DIT) || (kphase == PH_DAH);
        res.tx_enable = (kphase != PH_IDLE);
        res.phase     = kphase;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        ik_out_t want;
        if (!rst_n)
        begin
            kphase     = PH_IDLE;
            ticks      = '0;
            dit_mem    = 1'b0;
            dit_len    = dit_time_for(WPM_RESET);
            start_len  = START_DELAY_RESET;
            end_len    = END_DELAY_RESET;
            due_outputs.delete();
            miss_cnt   = 0;
            seen_cnt   = 0;
            mismatches <= 0;
            pending    <= 0;
            checked    <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen_cnt++;
                if (due_outputs.size() == 0)
                begin
                    if (miss_cnt < 10)
                        $display("unexpected output transfer: key=%0b tx=%0b phase=%0d",
                                 out_data.key_down, out_data.tx_enable, out_data.phase);
                    miss_cnt++;
                end
                else
                begin
                    want = due_outputs.pop_front();
                    if (out_data.key_down !== want.key_down ||
                        out_data.tx_enable !== want.tx_enable ||
                        out_data.phase !== want.phase)
                    begin
                        if (miss_cnt < 10)
                            $display({"output %0d: expected key=%0b tx=%0b phase=%0d,",
                                      " got key=%0b tx=%0b phase=%0d"},
                                     seen_cnt, want.key_down, want.tx_enable, want.phase,
                                     out_data.key_down, out_data.tx_enable, out_data.phase);
                        miss_cnt++;
                    end
                end
            end

            if (cfg_write)
            begin
                case (ik_reg_t'(cfg_index))
                    REG_WPM:         dit_len   = dit_time_for(cfg_data[5:0]);
                    REG_START_DELAY: start_len = cfg_data;
                    REG_END_DELAY:   end_len   = cfg_data;
                    default:         ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                step_keyer(in_data, want);
                due_outputs.push_back(want);
            end

            mismatches <= miss_cnt;
            pending    <= due_outputs.size();
            checked    <= seen_cnt;
        end
    end

endmodule

// ===== tb/tb_iambic_keyer.sv =====
`timescale 1ns / 100ps

// Testbench for the iambic keyer. The top only makes stimulus: paddle ticks
// with random sender gaps, random receiver stalls and register writes. All
// prediction and comparison lives in keyer_checker, which reports a mismatch
// count and the number of outputs still owed.
module tb_iambic_keyer;
    import ik_pkg::*;

    // Random part stops once this many ticks have been sent in total.
    localparam int TICK_TARGET = 2000;
    // Ticks between reconfigurations during the random part.
    localparam int CFG_SPACING = 200;
    // Long receiver hold-off; far longer than the block's two-deep buffering.
    localparam int SINK_HOLD   = 300;
    // Watchdog: cycles with no transfer on either channel before giving up.
    // The worst normal quiet stretch comes from the sink hold.
    localparam int QUIET_LIMIT = 3000;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [1:0]            cfg_index = REG_WPM;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    ik_in_t                in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    ik_out_t               out_data;

    int mismatch_count;
    int outstanding;
    int outputs_checked;

    // Shared between the sender and the receiver process.
    bit steady    = 1'b0;   // both sides run without idling while set
    bit hold_sink = 1'b0;   // request for one long receiver hold-off

    int ticks_sent  = 0;
    int reg_writes  = 0;
    int cfg_rounds  = 0;
    // Rough timing of the current setting, used only to size paddle holds.
    int unit        = 60;
    int start_ticks = 10;
    int end_ticks   = 50;

    iambic_keyer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    keyer_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .mismatches (mismatch_count),
        .pending    (outstanding),
        .checked    (outputs_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // One paddle tick. A random gap drops valid first; with no gap the next
    // tick goes out right behind the previous transfer, so valid stays high.
    // Returns in the step of the accepting edge with valid still high: the
    // caller's next action must either present a new tick or drop valid.
    task automatic send_tick(input bit dit, input bit dah);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{dit_pressed: dit, dah_pressed: dah};
        do
            @(posedge clk);
        while (in_stall);
        ticks_sent++;
    endtask

    // Holds are cut short once the tick target is reached.
    task automatic hold_paddles(input bit dit, input bit dah, input int n);
        repeat (n)
        begin
            if (ticks_sent < TICK_TARGET)
                send_tick(dit, dah);
        end
    endtask

    // Stop offering ticks and wait for every owed output. The first edge lets the
    // checker count a tick accepted on the edge we were called at.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (3) @(posedge clk);
    endtask

    // Keeps cfg_write high across back-to-back writes; the caller drops it.
    task automatic write_reg(input ik_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        reg_writes++;
    endtask

    // Written with the channels drained but the keyer possibly mid-element:
    // running countdowns must keep going, new values apply at the next load.
    task automatic reconfigure(input logic [7:0] wpm_val, input logic [7:0] sd,
                               input logic [7:0] ed);
        int w;
        drain();
        write_reg(REG_WPM, wpm_val);
        write_reg(REG_START_DELAY, sd);
        write_reg(REG_END_DELAY, ed);
        cfg_write <= 1'b0;
        w = wpm_val[5:0];
        if (w < 5)
            w = 5;
        if (w > 60)
            w = 60;
        unit        = 1200 / w;
        start_ticks = sd;
        end_ticks   = ed;
        cfg_rounds++;
    endtask

    // Zero and full-scale delays come up often, otherwise short ones.
    function automatic logic [7:0] pick_delay(int span);
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, span));
        endcase
    endfunction

    // Receiver: a random stall before each output transfer, plus one long
    // hold-off when the stimulus asks for it.
    initial
    begin : sink
        int wait_n;
        forever
        begin
            if (hold_sink)
            begin
                hold_sink = 1'b0;
                out_stall <= 1'b1;
                repeat (SINK_HOLD) @(posedge clk);
            end
            wait_n = steady ? 0 : $urandom_range(0, 15);
            if (wait_n != 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("** iambic_keyer: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        logic [1:0] opening [12];
        int         next_cfg;
        int         failures;
        bit         pressed;
        logic [7:0] wpm_pick;

        // From idle with zero delays: each paddle combination leaves idle,
        // start delay expiring with nothing held falls back to idle, and with
        // both held at expiry the dit wins.
        opening = '{2'b00, 2'b11, 2'b00, 2'b01, 2'b00, 2'b10,
                    2'b00, 2'b11, 2'b11, 2'b11, 2'b11, 2'b11};
        pressed = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a dit press loads the 10-tick start delay.
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);

        // Mid start delay: speed written as 0xFF (6-bit field reads 63, acts
        // as 60), both delays zero. The running countdown is untouched, so
        // eight released ticks run it out and the keyer drops to idle.
        reconfigure(8'hFF, 8'd0, 8'd0);
        @(posedge clk);
        write_reg(REG_NONE, 8'hFF);     // index beyond the map: ignored
        cfg_write <= 1'b0;
        hold_paddles(1'b0, 1'b0, 8);

        foreach (opening[i])
            send_tick(opening[i][1], opening[i][0]);

        // Random part: mostly well-formed paddle work with random lengths,
        // some noise, and a new setting every CFG_SPACING ticks.
        next_cfg = ticks_sent + CFG_SPACING;
        while (ticks_sent < TICK_TARGET)
        begin
            if (ticks_sent >= next_cfg)
            begin
                next_cfg = ticks_sent + CFG_SPACING;
                // First the extremes: slowest speed (below range) with full
                // delays, then fastest (above range) with one-tick delays.
                case (cfg_rounds)
                    1:       reconfigure(8'd4, 8'd255, 8'd255);
                    2:       reconfigure(8'd61, 8'd1, 8'd1);
                    3:       reconfigure(8'd60, 8'd0, 8'd255);
                    default:
                    begin
                        wpm_pick = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                               : 8'($urandom_range(30, 63));
                        reconfigure(wpm_pick, pick_delay(20), pick_delay(40));
                    end
                endcase
            end

            // One long receiver hold-off while the sender keeps going, so the
            // output buffering fills and the block stalls its input.
            if (!pressed && ticks_sent >= TICK_TARGET / 2)
            begin
                pressed   = 1'b1;
                steady    = 1'b1;
                hold_sink = 1'b1;
                hold_paddles(1'b1, 1'b1, 40);
            end

            steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 7))
                0: hold_paddles(1'b1, 1'b0, $urandom_range(1, 4 * unit));
                1: hold_paddles(1'b0, 1'b1, $urandom_range(1, 6 * unit));
                // both held: elements alternate
                2: hold_paddles(1'b1, 1'b1, $urandom_range(unit, 8 * unit));
                3:
                begin
                    // dah, then a short dit tap aimed at the dah gap
                    hold_paddles(1'b0, 1'b1,
                                 start_ticks + 3 * unit + $urandom_range(0, unit / 2));
                    hold_paddles(1'b1, 1'b0, $urandom_range(1, unit / 2));
                    hold_paddles(1'b0, bit'($urandom_range(0, 1)),
                                 $urandom_range(1, 2 * unit));
                end
                4:
                begin
                    // release, then press again somewhere in the end delay
                    hold_paddles(1'b0, 1'b0, $urandom_range(1, end_ticks + 2));
                    hold_paddles(bit'($urandom_range(0, 1)), 1'b1,
                                 $urandom_range(1, 3 * unit));
                end
                5:
                begin
                    repeat ($urandom_range(1, 40))
                        send_tick(bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)));
                end
                6: hold_paddles(1'b0, 1'b0, $urandom_range(1, start_ticks + end_ticks + 4));
                7:
                begin
                    // dit pressed while a dah is keyed
                    hold_paddles(1'b0, 1'b1, $urandom_range(1, 2 * unit));
                    hold_paddles(1'b1, 1'b1, $urandom_range(1, 2 * unit));
                end
            endcase
        end

        steady = 1'b0;
        drain();

        failures = mismatch_count + ((outstanding != 0) ? 1 : 0);
        $display("Sent %0d paddle ticks under %0d speed/delay settings (%0d register writes).",
                 ticks_sent, cfg_rounds + 1, reg_writes);
        $display("Checked %0d keyer outputs: %0d mismatches, %0d still owed.",
                 outputs_checked, mismatch_count, outstanding);
        if (failures == 0)
            $display("** iambic_keyer: PASSED **");
        else
            $display("** iambic_keyer: FAILED **");
        $finish;
    end

endmodule
